FILE: sv/spa_pkg.sv
`timescale 1ns / 1ps
package spa_pkg;

   // Pool geometry. SLAB_PAGES must be a power of two.
   localparam int TOTAL_PAGES = 1024;
   localparam int SLAB_PAGES  = 4;

   localparam int PAGE_W     = $clog2(TOTAL_PAGES);
   localparam int CNT_W      = $clog2(TOTAL_PAGES + 2);
   localparam int NXT_W      = PAGE_W + 1;
   localparam int TOT_W      = $clog2(TOTAL_PAGES + 1);
   localparam int NSLABS     = TOTAL_PAGES / SLAB_PAGES;
   localparam int SLAB_SHIFT = $clog2(SLAB_PAGES);
   localparam int SLAB_W     = PAGE_W - SLAB_SHIFT;
   localparam int SID_W      = SLAB_W + 1;
   localparam int FREE_W     = $clog2(SLAB_PAGES + 1);

   // Beat field widths.
   localparam int MODE_W     = 2;
   localparam int BASE_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - 1 - PAGE_W - TOT_W;

   localparam logic [NXT_W-1:0] NO_PAGE = NXT_W'(TOTAL_PAGES);
   localparam logic [SID_W-1:0] NO_SLAB = SID_W'(NSLABS);

   typedef enum logic [1:0] {
      MODE_GIVE  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      MARK_NONE = 2'd0,
      MARK_FREE = 2'd1,
      MARK_USED = 2'd2
   } mark_type;

   typedef struct packed {
      logic              used;
      logic              partial;
      logic [PAGE_W-1:0] base;
      logic [NXT_W-1:0]  head;
      logic [FREE_W-1:0] free_cnt;
   } slab_rec_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_GIVE_RD, ST_GIVE_WR,
      ST_FREE_RD, ST_FREE_CHK, ST_FREE_REC, ST_FREE_EVAL, ST_FREE_LIMIT,
      ST_ALLOC_START, ST_TAKE_CHK, ST_SCAN, ST_TAKE_EVAL, ST_TAKE_CLR,
      ST_SLAB_INIT, ST_SLAB_REC, ST_POP_RD, ST_POP_REC, ST_POP_WR, ST_POP_EVAL,
      ST_PUSH_LINK, ST_PUSH_HEAD, ST_REM_RD, ST_REM_WR, ST_RET, ST_FAIL, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NOP, CMD_CLEAR, CMD_LOAD, CMD_GIVE_RD, CMD_GIVE_WR,
      CMD_FREE_RD, CMD_FREE_OWN, CMD_FREE_REC, CMD_TAKE_INIT, CMD_SCAN,
      CMD_TAKE_CLR, CMD_SLAB_INIT, CMD_SLAB_REC, CMD_POP_RD, CMD_POP_REC,
      CMD_POP_WR, CMD_PUSH_LINK, CMD_PUSH_HEAD, CMD_REM_RD, CMD_REM_WR,
      CMD_RET, CMD_FAIL, CMD_DONE
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     n_zero;
      logic     n_one;
      logic     head_empty;
      mark_type mark;
      logic     take_bad;
      logic     found;
      logic     give_last;
      logic     clr_last;
      logic     scan_last;
      logic     tclr_last;
      logic     slab_last;
      logic     rec_used;
      logic     rec_partial;
      logic     rec_free_zero;
      logic     rec_free_one;
      logic     rec_free_full;
      logic     out_busy;
   } stat_type;

endpackage

FILE: sv/slab_page_allocator_best_fit_unit.sv
`timescale 1ns / 1ps
// Two-level physical page allocator over 1024 pages. Each request beat carries a mode in
// req_tuser (hand a range to the backend, allocate, or free) and answers with exactly one
// response beat: status, first allocated page and the total of free pages afterwards.
// Multi-page allocations take the low end of the smallest free run that fits (lowest
// address on ties); one-page allocations come from 4-page slabs kept on a partial stack.
// Requests are served one at a time. Hand and free of n pages touch pages below 1024 only;
// a one-page free of a slab page hands the slab back whole when the slab empties; an
// allocation that takes the last object of an open slab takes the slab off the stack; a
// rejected allocation (zero count or more than the free backend pages) fails; any allocation
// that needs backend pages scans every page free bit once through the single read port of
// the free-bit memory, and then builds a new slab if it serves a one-page request.
// After reset a clearing pass runs with req_tready low.
// A finished response waits in an output register, so the next request is taken while it
// is still pending; a response that is still stalled when the next one finishes holds the
// block until rsp_tready frees the register.
module slab_page_allocator_best_fit_unit
   import spa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // base_page[9:0], page_count[20:10], zero pad
   input  logic [MODE_W-1:0]     req_tuser,  // mode[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[0], first_page[10:1], free_total[21:11]
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer: walks each request through its memory steps.
   spa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Page/slab stores, scan logic, counters and the response register.
   spa_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: sv/spa_ctrl.sv
`timescale 1ns / 1ps
module spa_ctrl
   import spa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (stat.mode)
               MODE_GIVE:  state_in = stat.n_zero ? ST_DONE : ST_GIVE_RD;
               MODE_ALLOC: state_in = stat.n_one ? ST_ALLOC_START : ST_TAKE_CHK;
               MODE_FREE: begin
                  if (stat.n_one)       state_in = ST_FREE_RD;
                  else if (stat.n_zero) state_in = ST_DONE;
                  else                  state_in = ST_GIVE_RD;
               end
               default:    state_in = ST_DONE;
            endcase
         end
         ST_GIVE_RD: state_in = ST_GIVE_WR;
         ST_GIVE_WR: state_in = stat.give_last ? ST_DONE : ST_GIVE_RD;
         ST_FREE_RD: state_in = ST_FREE_CHK;
         ST_FREE_CHK: begin
            case (stat.mark)
               MARK_USED: state_in = ST_FREE_REC;
               MARK_FREE: state_in = ST_DONE;
               default:   state_in = ST_GIVE_RD;
            endcase
         end
         ST_FREE_REC: state_in = ST_FREE_EVAL;
         ST_FREE_EVAL: begin
            if (!stat.rec_used)
               state_in = ST_DONE;
            else if (stat.rec_free_one && !stat.rec_partial)
               state_in = ST_PUSH_LINK;
            else
               state_in = ST_FREE_LIMIT;
         end
         ST_FREE_LIMIT: begin
            if (stat.rec_free_full) state_in = stat.rec_partial ? ST_REM_RD : ST_RET;
            else                    state_in = ST_DONE;
         end
         ST_ALLOC_START: state_in = stat.head_empty ? ST_TAKE_CHK : ST_POP_RD;
         ST_TAKE_CHK:    state_in = stat.take_bad ? ST_FAIL : ST_SCAN;
         ST_SCAN:        state_in = stat.scan_last ? ST_TAKE_EVAL : ST_SCAN;
         ST_TAKE_EVAL:   state_in = stat.found ? ST_TAKE_CLR : ST_FAIL;
         ST_TAKE_CLR: begin
            if (stat.tclr_last) state_in = stat.n_one ? ST_SLAB_INIT : ST_DONE;
         end
         ST_SLAB_INIT: begin
            if (stat.slab_last) state_in = ST_SLAB_REC;
         end
         ST_SLAB_REC:  state_in = ST_POP_RD;
         ST_POP_RD:    state_in = ST_POP_REC;
         ST_POP_REC:   state_in = ST_POP_WR;
         ST_POP_WR:    state_in = ST_POP_EVAL;
         ST_POP_EVAL: begin
            state_in = (stat.rec_free_zero && stat.rec_partial) ? ST_REM_RD : ST_DONE;
         end
         ST_PUSH_LINK: state_in = ST_PUSH_HEAD;
         ST_PUSH_HEAD: state_in = ST_FREE_LIMIT;
         ST_REM_RD:    state_in = ST_REM_WR;
         ST_REM_WR:    state_in = (stat.mode == MODE_FREE) ? ST_RET : ST_DONE;
         ST_RET: begin
            if (stat.slab_last) state_in = ST_DONE;
         end
         ST_FAIL: state_in = ST_DONE;
         ST_DONE: begin
            if (!stat.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = CMD_NOP;
      case (state_ff)
         ST_CLEAR:     cmd = CMD_CLEAR;
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd = CMD_LOAD;
         end
         ST_GIVE_RD:   cmd = CMD_GIVE_RD;
         ST_GIVE_WR:   cmd = CMD_GIVE_WR;
         ST_FREE_RD:   cmd = CMD_FREE_RD;
         ST_FREE_CHK:  cmd = CMD_FREE_OWN;
         ST_FREE_REC:  cmd = CMD_FREE_REC;
         ST_TAKE_CHK:  cmd = CMD_TAKE_INIT;
         ST_SCAN:      cmd = CMD_SCAN;
         ST_TAKE_CLR:  cmd = CMD_TAKE_CLR;
         ST_SLAB_INIT: cmd = CMD_SLAB_INIT;
         ST_SLAB_REC:  cmd = CMD_SLAB_REC;
         ST_POP_RD:    cmd = CMD_POP_RD;
         ST_POP_REC:   cmd = CMD_POP_REC;
         ST_POP_WR:    cmd = CMD_POP_WR;
         ST_PUSH_LINK: cmd = CMD_PUSH_LINK;
         ST_PUSH_HEAD: cmd = CMD_PUSH_HEAD;
         ST_REM_RD:    cmd = CMD_REM_RD;
         ST_REM_WR:    cmd = CMD_REM_WR;
         ST_RET:       cmd = CMD_RET;
         ST_FAIL:      cmd = CMD_FAIL;
         ST_DONE:      cmd = CMD_DONE;
         default:      cmd = CMD_NOP;
      endcase
   end

endmodule

FILE: sv/spa_datapath.sv
`timescale 1ns / 1ps
module spa_datapath
   import spa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Page and slab stores
   logic         free_mem  [TOTAL_PAGES];
   mark_type     mark_mem  [TOTAL_PAGES];
   logic [NXT_W-1:0]  next_mem  [TOTAL_PAGES];
   logic [SLAB_W-1:0] owner_mem [TOTAL_PAGES];
   slab_rec_type rec_mem   [NSLABS];
   logic [SID_W-1:0]  lprev_mem [NSLABS];
   logic [SID_W-1:0]  lnext_mem [NSLABS];

   logic              free_rd_ff;
   mark_type          mark_rd_ff;
   logic [NXT_W-1:0]  next_rd_ff;
   logic [SLAB_W-1:0] owner_rd_ff;
   slab_rec_type      rec_rd_ff;
   logic [SID_W-1:0]  lprev_rd_ff, lnext_rd_ff;

   // Working registers
   mode_type           mode_ff, mode_in;
   logic [PAGE_W-1:0]  base_ff, base_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TOT_W-1:0]   backend_ff, backend_in;
   logic [TOT_W-1:0]   slabfree_ff, slabfree_in;
   logic [SID_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   run_len_ff, run_len_in;
   logic [PAGE_W-1:0]  run_start_ff, run_start_in;
   logic [CNT_W-1:0]   best_len_ff, best_len_in;
   logic [PAGE_W-1:0]  best_start_ff, best_start_in;
   logic [SLAB_W-1:0]  s_ff, s_in;
   logic [PAGE_W-1:0]  pg_ff, pg_in;
   slab_rec_type       rec_ff, rec_in;
   logic               status_ff, status_in;
   logic [PAGE_W-1:0]  idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory port controls
   logic [PAGE_W-1:0] page_raddr;
   logic [SLAB_W-1:0] rec_raddr;
   logic free_we, mark_we, next_we, owner_we, rec_we, lprev_we, lnext_we;
   logic [PAGE_W-1:0] free_wa, mark_wa, next_wa, owner_wa;
   logic [SLAB_W-1:0] rec_wa, lprev_wa, lnext_wa;
   logic              free_wd;
   mark_type          mark_wd;
   logic [NXT_W-1:0]  next_wd;
   logic [SLAB_W-1:0] owner_wd;
   slab_rec_type      rec_wd;
   logic [SID_W-1:0]  lprev_wd, lnext_wd;

   // Derived values
   logic [CNT_W-1:0]   cnt_inc, give_sum, give_nx;
   logic [COUNT_W-1:0] take_n;
   logic [PAGE_W-1:0]  slab_pa, ret_pa;
   logic [SLAB_W-1:0]  new_s;
   logic               scan_bit, give_hit;
   logic [TOT_W-1:0]   free_total;

   assign cnt_inc    = cnt_ff + 1'b1;
   assign give_sum   = CNT_W'(base_ff) + cnt_ff;
   assign give_nx    = give_sum + 1'b1;
   assign take_n     = stat.n_one ? COUNT_W'(SLAB_PAGES) : n_ff;
   assign slab_pa    = best_start_ff + PAGE_W'(cnt_ff);
   assign ret_pa     = rec_ff.base + PAGE_W'(cnt_ff);
   assign new_s      = best_start_ff[PAGE_W-1:SLAB_SHIFT];
   assign scan_bit   = (cnt_ff != CNT_W'(TOTAL_PAGES + 1)) && free_rd_ff;
   assign give_hit   = !free_rd_ff && (mark_rd_ff == MARK_NONE);
   assign free_total = backend_ff + slabfree_ff;

   always_comb begin
      stat.mode          = mode_ff;
      stat.n_zero        = (n_ff == '0);
      stat.n_one         = (n_ff == COUNT_W'(1));
      stat.head_empty    = (head_ff >= NO_SLAB);
      stat.mark          = mark_rd_ff;
      stat.take_bad      = (take_n == '0) || (take_n > COUNT_W'(backend_ff));
      stat.found         = (best_len_ff <= CNT_W'(TOTAL_PAGES));
      stat.give_last     = (cnt_inc >= CNT_W'(n_ff)) || (give_nx >= CNT_W'(TOTAL_PAGES));
      stat.clr_last      = (cnt_ff == CNT_W'(TOTAL_PAGES - 1));
      stat.scan_last     = (cnt_ff == CNT_W'(TOTAL_PAGES + 1));
      stat.tclr_last     = (cnt_inc == CNT_W'(take_n));
      stat.slab_last     = (cnt_ff == CNT_W'(SLAB_PAGES - 1));
      stat.rec_used      = rec_ff.used;
      stat.rec_partial   = rec_ff.partial;
      stat.rec_free_zero = (rec_ff.free_cnt == '0);
      stat.rec_free_one  = (rec_ff.free_cnt == FREE_W'(1));
      stat.rec_free_full = (rec_ff.free_cnt >= FREE_W'(SLAB_PAGES));
      stat.out_busy      = rsp_valid_ff && !rsp_tready;
   end

   // Memory addressing and write data per command
   always_comb begin
      page_raddr = base_ff;
      rec_raddr  = head_ff[SLAB_W-1:0];
      free_we  = 1'b0; free_wa  = '0; free_wd  = 1'b0;
      mark_we  = 1'b0; mark_wa  = '0; mark_wd  = MARK_NONE;
      next_we  = 1'b0; next_wa  = '0; next_wd  = NO_PAGE;
      owner_we = 1'b0; owner_wa = '0; owner_wd = new_s;
      rec_we   = 1'b0; rec_wa   = s_ff; rec_wd = rec_in;
      lprev_we = 1'b0; lprev_wa = s_ff; lprev_wd = NO_SLAB;
      lnext_we = 1'b0; lnext_wa = s_ff; lnext_wd = head_ff;
      case (cmd)
         CMD_CLEAR: begin
            free_we = 1'b1; free_wa = cnt_ff[PAGE_W-1:0];
            mark_we = 1'b1; mark_wa = cnt_ff[PAGE_W-1:0];
            rec_we  = 1'b1; rec_wa  = cnt_ff[SLAB_W-1:0]; rec_wd = '0;
         end
         CMD_GIVE_RD: page_raddr = give_sum[PAGE_W-1:0];
         CMD_GIVE_WR: begin
            free_we = give_hit; free_wa = give_sum[PAGE_W-1:0]; free_wd = 1'b1;
         end
         CMD_FREE_OWN: rec_raddr = owner_rd_ff;
         CMD_FREE_REC: begin
            next_we = rec_rd_ff.used; next_wa = base_ff; next_wd = rec_rd_ff.head;
            mark_we = rec_rd_ff.used; mark_wa = base_ff; mark_wd = MARK_FREE;
            rec_we  = rec_rd_ff.used;
         end
         CMD_SCAN: page_raddr = cnt_ff[PAGE_W-1:0];
         CMD_TAKE_CLR: begin
            free_we = 1'b1; free_wa = slab_pa;
         end
         CMD_SLAB_INIT: begin
            mark_we  = 1'b1; mark_wa  = slab_pa; mark_wd = MARK_FREE;
            owner_we = 1'b1; owner_wa = slab_pa;
            next_we  = 1'b1; next_wa  = slab_pa;
            next_wd  = stat.slab_last ? NO_PAGE : NXT_W'(slab_pa) + 1'b1;
         end
         CMD_SLAB_REC: begin
            rec_we   = 1'b1; rec_wa = new_s;
            lprev_we = 1'b1; lprev_wa = new_s;
            lnext_we = 1'b1; lnext_wa = new_s;
         end
         CMD_POP_REC: page_raddr = rec_rd_ff.head[PAGE_W-1:0];
         CMD_POP_WR: begin
            rec_we  = 1'b1;
            mark_we = 1'b1; mark_wa = pg_ff; mark_wd = MARK_USED;
            next_we = 1'b1; next_wa = pg_ff;
         end
         CMD_PUSH_LINK: begin
            lprev_we = 1'b1;
            lnext_we = 1'b1;
         end
         CMD_PUSH_HEAD: begin
            rec_we   = 1'b1;
            lprev_we = !stat.head_empty;
            lprev_wa = head_ff[SLAB_W-1:0];
            lprev_wd = {1'b0, s_ff};
         end
         CMD_REM_WR: begin
            rec_we   = 1'b1;
            lnext_we = (lprev_rd_ff < NO_SLAB);
            lnext_wa = lprev_rd_ff[SLAB_W-1:0];
            lnext_wd = lnext_rd_ff;
            lprev_we = (lnext_rd_ff < NO_SLAB);
            lprev_wa = lnext_rd_ff[SLAB_W-1:0];
            lprev_wd = lprev_rd_ff;
         end
         CMD_RET: begin
            mark_we = 1'b1; mark_wa = ret_pa;
            free_we = 1'b1; free_wa = ret_pa; free_wd = 1'b1;
            rec_we  = stat.slab_last;
         end
         default: begin
         end
      endcase
   end

   // Next values of the working registers
   always_comb begin
      mode_in       = mode_ff;
      base_in       = base_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      backend_in    = backend_ff;
      slabfree_in   = slabfree_ff;
      head_in       = head_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      s_in          = s_ff;
      pg_in         = pg_ff;
      rec_in        = rec_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (cmd)
         CMD_CLEAR: cnt_in = stat.clr_last ? '0 : cnt_inc;
         CMD_LOAD: begin
            mode_in   = mode_type'(req_tuser);
            base_in   = PAGE_W'(req_tdata[BASE_W-1:0]);
            n_in      = req_tdata[BASE_W +: COUNT_W];
            status_in = 1'b0;
            idx_in    = '0;
         end
         CMD_GIVE_WR: begin
            cnt_in = stat.give_last ? '0 : cnt_inc;
            if (give_hit) backend_in = backend_ff + 1'b1;
         end
         CMD_FREE_OWN: s_in = owner_rd_ff;
         CMD_FREE_REC: begin
            rec_in = rec_rd_ff;
            if (rec_rd_ff.used) begin
               rec_in.head     = NXT_W'(base_ff);
               rec_in.free_cnt = rec_rd_ff.free_cnt + 1'b1;
               slabfree_in     = slabfree_ff + 1'b1;
            end
         end
         CMD_TAKE_INIT: begin
            run_len_in  = '0;
            best_len_in = CNT_W'(TOTAL_PAGES + 1);
         end
         CMD_SCAN: begin
            cnt_in = stat.scan_last ? '0 : cnt_inc;
            if (cnt_ff != '0) begin
               if (scan_bit) begin
                  if (run_len_ff == '0) run_start_in = PAGE_W'(cnt_ff - 1'b1);
                  run_len_in = run_len_ff + 1'b1;
               end else begin
                  if ((run_len_ff >= CNT_W'(take_n)) && (run_len_ff < best_len_ff)) begin
                     best_len_in   = run_len_ff;
                     best_start_in = run_start_ff;
                  end
                  run_len_in = '0;
               end
            end
         end
         CMD_TAKE_CLR: begin
            cnt_in = stat.tclr_last ? '0 : cnt_inc;
            if (stat.tclr_last) begin
               backend_in = backend_ff - TOT_W'(take_n);
               idx_in     = best_start_ff;
            end
         end
         CMD_SLAB_INIT: cnt_in = stat.slab_last ? '0 : cnt_inc;
         CMD_SLAB_REC: begin
            rec_in.used     = 1'b1;
            rec_in.partial  = 1'b1;
            rec_in.base     = best_start_ff;
            rec_in.head     = NXT_W'(best_start_ff);
            rec_in.free_cnt = FREE_W'(SLAB_PAGES);
            head_in         = {1'b0, new_s};
            slabfree_in     = slabfree_ff + TOT_W'(SLAB_PAGES);
         end
         CMD_POP_RD: s_in = head_ff[SLAB_W-1:0];
         CMD_POP_REC: begin
            rec_in = rec_rd_ff;
            pg_in  = rec_rd_ff.head[PAGE_W-1:0];
         end
         CMD_POP_WR: begin
            rec_in.head     = next_rd_ff;
            rec_in.free_cnt = rec_ff.free_cnt - 1'b1;
            slabfree_in     = slabfree_ff - 1'b1;
            idx_in          = pg_ff;
         end
         CMD_PUSH_HEAD: begin
            rec_in.partial = 1'b1;
            head_in        = {1'b0, s_ff};
         end
         CMD_REM_WR: begin
            rec_in.partial = 1'b0;
            if (lprev_rd_ff >= NO_SLAB) head_in = lnext_rd_ff;
         end
         CMD_RET: begin
            cnt_in = stat.slab_last ? '0 : cnt_inc;
            if (stat.slab_last) begin
               rec_in.used     = 1'b0;
               rec_in.free_cnt = '0;
               rec_in.head     = NO_PAGE;
               backend_in      = backend_ff + TOT_W'(SLAB_PAGES);
               slabfree_in     = slabfree_ff - TOT_W'(SLAB_PAGES);
            end
         end
         CMD_FAIL: begin
            status_in = 1'b1;
            idx_in    = '0;
         end
         CMD_DONE: begin
            if (!stat.out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, free_total, idx_ff, status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         backend_ff   <= '0;
         slabfree_ff  <= '0;
         head_ff      <= NO_SLAB;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         backend_ff   <= backend_in;
         slabfree_ff  <= slabfree_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      base_ff       <= base_in;
      n_ff          <= n_in;
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      s_ff          <= s_in;
      pg_ff         <= pg_in;
      rec_ff        <= rec_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (free_we)  free_mem[free_wa]   <= free_wd;
      if (mark_we)  mark_mem[mark_wa]   <= mark_wd;
      if (next_we)  next_mem[next_wa]   <= next_wd;
      if (owner_we) owner_mem[owner_wa] <= owner_wd;
      if (rec_we)   rec_mem[rec_wa]     <= rec_wd;
      if (lprev_we) lprev_mem[lprev_wa] <= lprev_wd;
      if (lnext_we) lnext_mem[lnext_wa] <= lnext_wd;
      free_rd_ff  <= free_mem[page_raddr];
      mark_rd_ff  <= mark_mem[page_raddr];
      next_rd_ff  <= next_mem[page_raddr];
      owner_rd_ff <= owner_mem[page_raddr];
      rec_rd_ff   <= rec_mem[rec_raddr];
      lprev_rd_ff <= lprev_mem[s_ff];
      lnext_rd_ff <= lnext_mem[s_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sv/spa_checker.sv
`timescale 1ns / 1ps
module spa_checker
   import spa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[PAGE_W:1] == '0)
      else $error("failed allocation carries a page index");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PAGE_W+TOT_W:PAGE_W+1] <= TOT_W'(TOTAL_PAGES))
      else $error("free total above pool size");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind slab_page_allocator_best_fit_unit spa_checker u_spa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/tb_slab_page_allocator_best_fit_unit.sv
`timescale 1ns / 1ps
module tb_slab_page_allocator_best_fit_unit;
   import spa_pkg::*;

   localparam int NUM_SLABS  = TOTAL_PAGES / SLAB_PAGES;
   localparam int END_PAGE   = TOTAL_PAGES;
   localparam int RAND_ITEMS = 520;
   localparam int CYCLE_CAP  = 20000000;

   typedef struct {
      mode_type         mode;
      logic [BASE_W-1:0]  base;
      logic [COUNT_W-1:0] count;
      bit                 drain;
   } page_req_type;

   typedef struct {
      logic              status;
      logic [PAGE_W-1:0] index;
      logic [TOT_W-1:0]  total;
   } page_rsp_type;

   typedef struct {
      int base;
      int count;
   } block_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   slab_page_allocator_best_fit_unit uut (.*);

   always #2 clock = ~clock;

   // Shadow allocator state.
   bit       pg_free  [TOTAL_PAGES];
   mark_type pg_mark  [TOTAL_PAGES];
   int       pg_next  [TOTAL_PAGES];
   int       pg_owner [TOTAL_PAGES];
   bit       sl_used  [NUM_SLABS];
   bit       sl_part  [NUM_SLABS];
   int       sl_base  [NUM_SLABS];
   int       sl_head  [NUM_SLABS];
   int       sl_free  [NUM_SLABS];
   int       lk_prev  [NUM_SLABS];
   int       lk_next  [NUM_SLABS];
   int       part_top = NUM_SLABS;
   int       backend_cnt = 0;
   int       object_cnt = 0;

   page_req_type pending_beats[$];
   page_rsp_type expected_rsp[$];
   block_type    live_blocks[$];

   int  n_total = 0;
   int  n_sent = 0;
   int  n_acc = 0;
   int  n_rsp = 0;
   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  failed = 1'b0;
   longint cycles = 0;

   function automatic void release_range(int base, int count);
      int p;
      for (int i = 0; i < count; i++) begin
         p = base + i;
         if (p >= TOTAL_PAGES) break;
         if (!pg_free[p] && pg_mark[p] == MARK_NONE) begin
            pg_free[p] = 1'b1;
            backend_cnt++;
         end
      end
   endfunction

   // Best fit: smallest run that fits, lowest address on ties.
   function automatic bit best_fit_take(int n, output int where);
      int rs, rl, bs, bl;
      rs = 0; rl = 0; bs = 0; bl = TOTAL_PAGES + 1;
      where = 0;
      if (n == 0 || n > backend_cnt) return 1'b0;
      for (int p = 0; p <= TOTAL_PAGES; p++) begin
         if (p < TOTAL_PAGES && pg_free[p]) begin
            if (rl == 0) rs = p;
            rl++;
         end else begin
            if (rl >= n && rl < bl) begin
               bl = rl;
               bs = rs;
            end
            rl = 0;
         end
      end
      if (bl > TOTAL_PAGES) return 1'b0;
      for (int p = 0; p < n; p++) pg_free[bs + p] = 1'b0;
      backend_cnt -= n;
      where = bs;
      return 1'b1;
   endfunction

   function automatic void stack_push(int s);
      if (sl_part[s]) return;
      lk_prev[s] = NUM_SLABS;
      lk_next[s] = part_top;
      if (part_top < NUM_SLABS) lk_prev[part_top] = s;
      part_top = s;
      sl_part[s] = 1'b1;
   endfunction

   function automatic void stack_unlink(int s);
      int pv, nx;
      if (!sl_part[s]) return;
      pv = lk_prev[s];
      nx = lk_next[s];
      if (pv < NUM_SLABS) lk_next[pv] = nx;
      else part_top = nx;
      if (nx < NUM_SLABS) lk_prev[nx] = pv;
      sl_part[s] = 1'b0;
   endfunction

   function automatic bit slab_object_take(output int where);
      int s, b, pg;
      where = 0;
      if (part_top >= NUM_SLABS) begin
         if (!best_fit_take(SLAB_PAGES, b)) return 1'b0;
         s = b / SLAB_PAGES;
         sl_used[s] = 1'b1;
         sl_part[s] = 1'b0;
         sl_base[s] = b;
         sl_head[s] = b;
         sl_free[s] = SLAB_PAGES;
         for (int i = 0; i < SLAB_PAGES; i++) begin
            pg_mark[b + i]  = MARK_FREE;
            pg_owner[b + i] = s;
            pg_next[b + i]  = (i + 1 < SLAB_PAGES) ? b + i + 1 : END_PAGE;
         end
         object_cnt += SLAB_PAGES;
         stack_push(s);
      end
      s = part_top;
      pg = sl_head[s];
      if (pg >= TOTAL_PAGES) return 1'b0;
      sl_head[s] = pg_next[pg];
      sl_free[s]--;
      object_cnt--;
      pg_mark[pg] = MARK_USED;
      pg_next[pg] = END_PAGE;
      if (sl_free[s] == 0) stack_unlink(s);
      where = pg;
      return 1'b1;
   endfunction

   // Return an object; hand the slab back whole once every object is free.
   function automatic void slab_object_return(int pg);
      int s;
      s = pg_owner[pg];
      if (s >= NUM_SLABS || !sl_used[s]) return;
      pg_next[pg] = sl_head[s];
      pg_mark[pg] = MARK_FREE;
      sl_head[s] = pg;
      sl_free[s]++;
      object_cnt++;
      if (sl_free[s] == 1) stack_push(s);
      if (sl_free[s] >= SLAB_PAGES) begin
         stack_unlink(s);
         for (int i = 0; i < SLAB_PAGES; i++) begin
            pg_mark[sl_base[s] + i] = MARK_NONE;
            pg_next[sl_base[s] + i] = END_PAGE;
         end
         object_cnt -= SLAB_PAGES;
         sl_used[s] = 1'b0;
         sl_free[s] = 0;
         sl_head[s] = END_PAGE;
         release_range(sl_base[s], SLAB_PAGES);
      end
   endfunction

   function automatic page_rsp_type allocator_step(page_req_type q);
      page_rsp_type r;
      int idx, n, b;
      bit ok;
      idx = 0;
      n = q.count;
      b = q.base;
      r.status = 1'b0;
      case (q.mode)
         MODE_GIVE: release_range(b, n);
         MODE_ALLOC: begin
            if (n == 1) ok = slab_object_take(idx);
            else ok = best_fit_take(n, idx);
            if (!ok) begin
               r.status = 1'b1;
               idx = 0;
            end
         end
         MODE_FREE: begin
            if (n == 1 && pg_mark[b] != MARK_NONE) begin
               if (pg_mark[b] == MARK_USED) slab_object_return(b);
            end else begin
               release_range(b, n);
            end
         end
         default: ;
      endcase
      r.index = idx[PAGE_W-1:0];
      r.total = TOT_W'(backend_cnt + object_cnt);
      return r;
   endfunction

   // Queue one beat, predict its response, and track live allocations.
   task automatic push_beat(mode_type m, int base, int count, bit drain = 1'b0);
      page_req_type q;
      page_rsp_type r;
      block_type blk;
      q.mode  = m;
      q.base  = base[BASE_W-1:0];
      q.count = count[COUNT_W-1:0];
      q.drain = drain;
      r = allocator_step(q);
      pending_beats.push_back(q);
      expected_rsp.push_back(r);
      n_total++;
      if (m == MODE_ALLOC && !r.status) begin
         blk.base  = r.index;
         blk.count = q.count;
         live_blocks.push_back(blk);
      end
   endtask

   task automatic free_live(bit corrupt);
      block_type blk;
      int k;
      k = $urandom_range(live_blocks.size() - 1);
      blk = live_blocks[k];
      live_blocks.delete(k);
      if (corrupt) push_beat(MODE_FREE, blk.base, $urandom_range(blk.count + 2, 1));
      else push_beat(MODE_FREE, blk.base, blk.count);
   endtask

   // Driver: advance to the next beat when the bus is free; hold for drain requests.
   always @(posedge clock) begin
      int ph;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) n_acc <= n_acc + 1;
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() > 0 &&
                !(pending_beats[0].drain &&
                  (n_acc != n_rsp || req_tvalid || rsp_tvalid)) &&
                $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, pending_beats[0].count, pending_beats[0].base};
               req_tuser  <= pending_beats[0].mode;
               void'(pending_beats.pop_front());
               n_sent <= n_sent + 1;
               ph = (4 * n_sent) / (n_total + 1);
               idle_pct  <= (ph == 1 || ph == 3) ? ((ph == 1) ? 76 : 26) : 0;
               stall_pct <= (ph == 2 || ph == 3) ? ((ph == 2) ? 76 : 26) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random and check each response beat against the oldest prediction.
   always @(posedge clock) begin
      page_rsp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0 || n_rsp >= n_acc + (req_tvalid && req_tready)) begin
               $display("%0t: unexpected response beat %h", $time, rsp_tdata);
               failed = 1'b1;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_tdata[0] !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_tdata[0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[10:1] !== e.index) begin
                  $display("%0t: first_page expected %0d actual %0d",
                           $time, e.index, rsp_tdata[10:1]);
                  failed = 1'b1;
               end
               if (rsp_tdata[21:11] !== e.total) begin
                  $display("%0t: free_total expected %0d actual %0d",
                           $time, e.total, rsp_tdata[21:11]);
                  failed = 1'b1;
               end
            end
            n_rsp <= n_rsp + 1;
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int r, n;
      for (int p = 0; p < TOTAL_PAGES; p++) begin
         pg_free[p] = 1'b0;
         pg_mark[p] = MARK_NONE;
         pg_next[p] = 0;
         pg_owner[p] = 0;
      end
      for (int s = 0; s < NUM_SLABS; s++) begin
         sl_used[s] = 1'b0; sl_part[s] = 1'b0; sl_base[s] = 0;
         sl_head[s] = 0; sl_free[s] = 0; lk_prev[s] = 0; lk_next[s] = 0;
      end

      // Directed: empty pool, zero counts, unused mode, whole-pool runs, slab corner cases.
      push_beat(MODE_ALLOC, 0, 1);
      push_beat(MODE_GIVE, 5, 0);
      push_beat(MODE_NONE, 1023, 2047);
      push_beat(MODE_GIVE, 0, 1024);
      push_beat(MODE_GIVE, 1020, 2047);
      push_beat(MODE_ALLOC, 0, 0);
      push_beat(MODE_ALLOC, 0, 2047);
      push_beat(MODE_ALLOC, 0, 1024);
      push_beat(MODE_ALLOC, 0, 1);
      push_beat(MODE_FREE, 0, 1024);
      push_beat(MODE_FREE, 1023, 0);
      push_beat(MODE_ALLOC, 0, 1);
      push_beat(MODE_ALLOC, 0, 1);
      push_beat(MODE_ALLOC, 0, 5);
      push_beat(MODE_ALLOC, 0, 3);
      push_beat(MODE_FREE, live_blocks[0].base, 1);
      push_beat(MODE_FREE, live_blocks[0].base, 1);
      push_beat(MODE_FREE, live_blocks[2].base, 5);
      push_beat(MODE_FREE, live_blocks[2].base, 5);
      push_beat(MODE_FREE, live_blocks[1].base, 1);
      push_beat(MODE_FREE, live_blocks[3].base, 3);
      push_beat(MODE_FREE, 1023, 1);
      live_blocks.delete();

      // Random: mostly allocate/free pairs on live blocks, plus noise.
      for (int i = 0; i < RAND_ITEMS; i++) begin
         r = $urandom_range(99);
         if (i == RAND_ITEMS / 2) begin
            push_beat(MODE_ALLOC, $urandom_range(1023), 1, 1'b1);
         end else if (r < 45) begin
            n = $urandom_range(99);
            if (n < 70) n = 1;
            else if (n < 92) n = $urandom_range(8, 2);
            else if (n < 98) n = $urandom_range(64, 9);
            else n = $urandom_range(2047, 65);
            push_beat(MODE_ALLOC, $urandom_range(1023), n);
         end else if (r < 85 && live_blocks.size() > 0) begin
            free_live($urandom_range(9) == 0);
         end else if (r < 93) begin
            push_beat(MODE_GIVE, $urandom_range(1023), $urandom_range(8, 1));
         end else if (r < 97) begin
            push_beat(MODE_FREE, $urandom_range(1023), 1);
         end else begin
            push_beat(MODE_NONE, $urandom_range(1023), $urandom_range(2047));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_beats.size() == 0 && n_rsp == n_total);
      repeat (2200) @(posedge clock);
      if (!failed && expected_rsp.size() == 0 && n_rsp == n_total) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/spa_pkg.sv
sv/spa_ctrl.sv
sv/spa_datapath.sv
sv/slab_page_allocator_best_fit_unit.sv
sv/spa_checker.sv
tb/tb_slab_page_allocator_best_fit_unit.sv
